/* design/mvg_pkg.sv */
`timescale 1ns / 1ps

package mvg_pkg;

    // Field widths fixed by the interface
    localparam int CW  = 20;             // coordinate
    localparam int IW  = 10;             // vertex index
    localparam int PW  = 2 * CW;         // coordinate product
    localparam int RW  = PW + 1;         // cross product component
    localparam int DPW = CW + RW;        // volume partial product
    localparam int GW  = 48;             // gradient component
    localparam int VW  = 64;             // volume accumulator

    // Operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_CORNER = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;   // ignored

    // Corner slots
    localparam logic [1:0] SLOT_0    = 2'd0;
    localparam logic [1:0] SLOT_1    = 2'd1;
    localparam logic [1:0] SLOT_LAST = 2'd2;
    localparam logic [1:0] SLOT_NONE = 2'd3;   // ignored

    // Result kinds
    localparam logic KIND_VOLUME = 1'b0;
    localparam logic KIND_GRAD   = 1'b1;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_CROSS = 10'b00_0000_0100,
        S_VOL   = 10'b00_0000_1000,
        S_ACC   = 10'b00_0001_0000,
        S_RD    = 10'b00_0010_0000,
        S_WR    = 10'b00_0100_0000,
        S_DONE  = 10'b00_1000_0000,
        S_GRD   = 10'b01_0000_0000,
        S_GOUT  = 10'b10_0000_0000
    } t_state;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [RW-1:0] t_cross;
    typedef logic signed [GW-1:0] t_grad;

    // Step a count modulo three
    function automatic logic [1:0] mod3_inc(input logic [1:0] x);
        mod3_inc = (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

endpackage

/* design/mesh_volume_and_gradient.sv */
`timescale 1ns / 1ps

// Triangle word: from accept to o_done it runs 9 cross steps, 4 volume
// steps, 1 volume add, three gradient read-modify-writes and 1 result.
// Gradient read word: a memory read, then the result register.
// Clear word and reset: a clearing pass over all NUM_VERTICES words of the
// gradient memory with busy high. One word is in work at a time; the next
// is taken once busy drops. Results are one-cycle strobes; no stall input.
module mesh_volume_and_gradient #(
    parameter int NUM_VERTICES = 1024,
    parameter int COORD_BITS   = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_opcode,
    input  logic [1:0]                i_corner_slot,
    input  logic [mvg_pkg::IW-1:0]    i_vertex_index,
    input  logic signed [19:0]        i_coord_x,
    input  logic signed [19:0]        i_coord_y,
    input  logic signed [19:0]        i_coord_z,
    output logic                      o_done,
    output logic                      o_result_kind,
    output logic signed [63:0]        o_volume_sum,
    output logic signed [47:0]        o_grad_x,
    output logic signed [47:0]        o_grad_y,
    output logic signed [47:0]        o_grad_z,
    output logic                      o_overflow
);
    import mvg_pkg::*;

    localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int MW = 3 * GW;

    t_state             r_state;
    logic [AW-1:0]      r_clr;
    logic [1:0]         r_n;
    logic [1:0]         r_m;
    logic [1:0]         r_c;
    t_coord             r_v   [3][3];
    logic [IW-1:0]      r_idx [3];
    t_cross             r_r   [3][3];
    logic signed [DPW-1:0] r_prod;
    logic signed [VW-1:0]  r_dv;
    logic signed [VW-1:0]  r_vol;
    logic               r_flag;
    logic [IW-1:0]      r_ridx;
    logic [MW-1:0]      r_rdata;
    logic [MW-1:0]      mem [NUM_VERTICES];

    logic               accept;
    t_coord             cur_v [3];
    logic [1:0]         sel_a, sel_b, sel_p, sel_q, vol_k;
    logic signed [PW-1:0] prod_pq, prod_qp;
    t_cross             n_cross;
    logic signed [VW:0] vol_sum;
    logic signed [VW-1:0] n_vol;
    logic               vol_sat;
    logic [MW-1:0]      n_grad;
    logic               grad_sat;
    logic               wr_in_range;
    logic               rd_in_range;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [MW-1:0]      mem_wd;
    logic [AW-1:0]      mem_ra;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Sign-extend the used coordinate bits
    assign cur_v[0] = CW'(signed'(i_coord_x[COORD_BITS-1:0]));
    assign cur_v[1] = CW'(signed'(i_coord_y[COORD_BITS-1:0]));
    assign cur_v[2] = CW'(signed'(i_coord_z[COORD_BITS-1:0]));

    // One cross product component per cycle: r_n = a x b, a = v(n+1), b = v(n+2)
    always_comb begin
        sel_a   = mod3_inc(r_n);
        sel_b   = mod3_inc(sel_a);
        sel_p   = mod3_inc(r_m);
        sel_q   = mod3_inc(sel_p);
        prod_pq = r_v[sel_a][sel_p] * r_v[sel_b][sel_q];
        prod_qp = r_v[sel_a][sel_q] * r_v[sel_b][sel_p];
        n_cross = RW'(prod_pq) - RW'(prod_qp);
    end

    assign vol_k = (r_m == 2'd3) ? 2'd0 : r_m;

    // Saturating volume add
    always_comb begin
        vol_sum = (VW+1)'(r_vol) + (VW+1)'(r_dv);
        vol_sat = (vol_sum[VW] != vol_sum[VW-1]);
        if (vol_sat) begin
            n_vol = vol_sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            n_vol = vol_sum[VW-1:0];
        end
    end

    // Saturating gradient add, one component per lane
    always_comb begin
        logic signed [GW:0] s;
        n_grad   = '0;
        grad_sat = 1'b0;
        s        = '0;
        for (int k = 0; k < 3; k++) begin
            s = (GW+1)'(signed'(r_rdata[k*GW +: GW])) + (GW+1)'(r_r[r_c][k]);
            if (s[GW] != s[GW-1]) begin
                grad_sat = 1'b1;
                n_grad[k*GW +: GW] = s[GW] ? {1'b1, {(GW-1){1'b0}}}
                                           : {1'b0, {(GW-1){1'b1}}};
            end else begin
                n_grad[k*GW +: GW] = s[GW-1:0];
            end
        end
    end

    assign wr_in_range = (32'(r_idx[r_c]) < NUM_VERTICES);
    assign rd_in_range = (32'(r_ridx) < NUM_VERTICES);

    // Memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = '0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == S_WR && wr_in_range) begin
            mem_we = 1'b1;
            mem_wa = AW'(r_idx[r_c]);
            mem_wd = n_grad;
        end
        mem_ra = (r_state == S_GRD) ? AW'(r_ridx) : AW'(r_idx[r_c]);
    end

    // Gradient memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_n     <= '0;
            r_m     <= '0;
            r_c     <= '0;
            r_vol   <= '0;
            r_flag  <= 1'b0;
            o_done  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_idx[i] <= '0;
                for (int j = 0; j < 3; j++) begin
                    r_v[i][j] <= '0;
                end
            end
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NUM_VERTICES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_opcode == OP_CLEAR) begin
                            r_state <= S_CLEAR;
                            r_clr   <= '0;
                            r_vol   <= '0;
                            r_flag  <= 1'b0;
                            for (int i = 0; i < 3; i++) begin
                                r_idx[i] <= '0;
                                for (int j = 0; j < 3; j++) begin
                                    r_v[i][j] <= '0;
                                end
                            end
                        end else if (i_opcode == OP_CORNER && i_corner_slot != SLOT_NONE) begin
                            r_idx[i_corner_slot] <= i_vertex_index;
                            for (int j = 0; j < 3; j++) begin
                                r_v[i_corner_slot][j] <= cur_v[j];
                            end
                            if (i_corner_slot == SLOT_LAST) begin
                                r_state <= S_CROSS;
                                r_n     <= '0;
                                r_m     <= '0;
                            end
                        end else if (i_opcode == OP_READ) begin
                            r_ridx  <= i_vertex_index;
                            r_state <= S_GRD;
                        end
                    end
                end
                S_CROSS: begin
                    r_r[r_n][r_m] <= n_cross;
                    if (r_m == 2'd2) begin
                        r_m <= '0;
                        if (r_n == 2'd2) begin
                            r_state <= S_VOL;
                            r_dv    <= '0;
                        end else begin
                            r_n <= r_n + 2'd1;
                        end
                    end else begin
                        r_m <= r_m + 2'd1;
                    end
                end
                S_VOL: begin
                    // Multiply one term, accumulate the previous one
                    if (r_m != 2'd3) begin
                        r_prod <= r_v[0][vol_k] * r_r[0][vol_k];
                    end
                    if (r_m != 2'd0) begin
                        r_dv <= r_dv + VW'(r_prod);
                    end
                    if (r_m == 2'd3) begin
                        r_state <= S_ACC;
                    end else begin
                        r_m <= r_m + 2'd1;
                    end
                end
                S_ACC: begin
                    r_vol   <= n_vol;
                    r_flag  <= r_flag | vol_sat;
                    r_c     <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (wr_in_range && grad_sat) begin
                        r_flag <= 1'b1;
                    end
                    if (r_c == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_c     <= r_c + 2'd1;
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    o_done        <= 1'b1;
                    o_result_kind <= KIND_VOLUME;
                    o_volume_sum  <= r_vol;
                    o_grad_x      <= '0;
                    o_grad_y      <= '0;
                    o_grad_z      <= '0;
                    o_overflow    <= r_flag;
                    r_state       <= S_IDLE;
                end
                S_GRD: begin
                    r_state <= S_GOUT;
                end
                S_GOUT: begin
                    o_done        <= 1'b1;
                    o_result_kind <= KIND_GRAD;
                    o_volume_sum  <= r_vol;
                    o_grad_x      <= rd_in_range ? r_rdata[0*GW +: GW] : '0;
                    o_grad_y      <= rd_in_range ? r_rdata[1*GW +: GW] : '0;
                    o_grad_z      <= rd_in_range ? r_rdata[2*GW +: GW] : '0;
                    o_overflow    <= r_flag;
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_clear_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_CLEAR) |=> busy)
        else $error("clear word did not start the clearing pass");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    a_no_done_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_done)
        else $error("result during clearing pass");

    a_write_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> $past(r_state == S_RD))
        else $error("gradient write without a preceding read");

endmodule

/* bench/mvg_checker.sv */
`timescale 1ns / 1ps

module mvg_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [1:0]             i_opcode,
    input  logic [1:0]             i_corner_slot,
    input  logic [9:0]             i_vertex_index,
    input  logic signed [19:0]     i_coord_x,
    input  logic signed [19:0]     i_coord_y,
    input  logic signed [19:0]     i_coord_z,
    input  logic                   o_done,
    input  logic                   o_result_kind,
    input  logic signed [63:0]     o_volume_sum,
    input  logic signed [47:0]     o_grad_x,
    input  logic signed [47:0]     o_grad_y,
    input  logic signed [47:0]     o_grad_z,
    input  logic                   o_overflow,
    output int                     o_errors,
    output int                     o_pending
);
    import mvg_pkg::*;

    localparam int NVERT = 1024;
    localparam longint GMAX = 64'sd140737488355327;
    localparam longint GMIN = -64'sd140737488355328;

    typedef struct {
        logic               kind;
        logic signed [63:0] vol;
        logic signed [47:0] gx;
        logic signed [47:0] gy;
        logic signed [47:0] gz;
        logic               ovf;
    } t_word_out;

    typedef struct {
        logic [9:0] idx;
        longint     c [3];
    } t_corner;

    t_word_out          expected_words [$];
    logic signed [47:0] grad_mem [0:3*NVERT-1];
    logic signed [63:0] volume;
    t_corner            latched [2];
    logic               sat;

    assign o_pending = expected_words.size();

    // Wipe volume, gradients, corner latches and the sticky flag
    task automatic clear_mesh();
        for (int i = 0; i < 3 * NVERT; i++) grad_mem[i] = '0;
        for (int j = 0; j < 2; j++) begin
            latched[j].idx = '0;
            for (int k = 0; k < 3; k++) latched[j].c[k] = 0;
        end
        volume = '0;
        sat = 1'b0;
    endtask

    function automatic void cross_prod(input longint a [3], input longint b [3],
                                       output longint r [3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Saturating add of a cross product into one vertex's gradient
    task automatic add_gradient(input logic [9:0] idx, input longint r [3]);
        longint s;
        for (int k = 0; k < 3; k++) begin
            s = longint'(grad_mem[idx * 3 + k]) + r[k];
            if (s > GMAX) begin
                s = GMAX;
                sat = 1'b1;
            end
            if (s < GMIN) begin
                s = GMIN;
                sat = 1'b1;
            end
            grad_mem[idx * 3 + k] = s[47:0];
        end
    endtask

    task automatic add_volume(input longint dv);
        logic signed [64:0] s;
        s = {volume[63], volume} + {dv[63], dv};
        if (s > 65'sd9223372036854775807) begin
            volume = 64'h7FFF_FFFF_FFFF_FFFF;
            sat = 1'b1;
        end else if (s < -65'sd9223372036854775808) begin
            volume = 64'h8000_0000_0000_0000;
            sat = 1'b1;
        end else begin
            volume = s[63:0];
        end
    endtask

    // Update the mesh state for one accepted word and queue its result, if any
    task automatic predict_word();
        t_corner   cur;
        longint    r0 [3], r1 [3], r2 [3];
        longint    dv;
        t_word_out w;
        cur.idx  = i_vertex_index;
        cur.c[0] = i_coord_x;
        cur.c[1] = i_coord_y;
        cur.c[2] = i_coord_z;
        case (i_opcode)
            OP_CLEAR: clear_mesh();
            OP_CORNER: begin
                if (i_corner_slot == SLOT_0 || i_corner_slot == SLOT_1) begin
                    latched[i_corner_slot] = cur;
                end else if (i_corner_slot == SLOT_LAST) begin
                    cross_prod(latched[1].c, cur.c, r0);
                    cross_prod(cur.c, latched[0].c, r1);
                    cross_prod(latched[0].c, latched[1].c, r2);
                    dv = latched[0].c[0] * r0[0] + latched[0].c[1] * r0[1]
                       + latched[0].c[2] * r0[2];
                    add_volume(dv);
                    add_gradient(latched[0].idx, r0);
                    add_gradient(latched[1].idx, r1);
                    add_gradient(cur.idx, r2);
                    w = '{KIND_VOLUME, volume, '0, '0, '0, sat};
                    expected_words.push_back(w);
                end
            end
            OP_READ: begin
                w = '{KIND_GRAD, volume, grad_mem[cur.idx * 3],
                      grad_mem[cur.idx * 3 + 1], grad_mem[cur.idx * 3 + 2], sat};
                expected_words.push_back(w);
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic signed [63:0] exp_v,
                          input logic signed [63:0] act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        clear_mesh();
    end

    // Compare results first, then take in the word accepted at this edge
    always @(posedge i_clk) begin
        t_word_out w;
        if (!i_rst_n) begin
            clear_mesh();
        end else begin
            if (o_done) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result with none expected, volume %0d", $time,
                             o_volume_sum);
                    o_errors++;
                end else begin
                    w = expected_words.pop_front();
                    if (o_result_kind !== w.kind) report("kind", w.kind, o_result_kind);
                    if (o_volume_sum !== w.vol) report("volume", w.vol, o_volume_sum);
                    if (o_grad_x !== w.gx) report("grad_x", w.gx, o_grad_x);
                    if (o_grad_y !== w.gy) report("grad_y", w.gy, o_grad_y);
                    if (o_grad_z !== w.gz) report("grad_z", w.gz, o_grad_z);
                    if (o_overflow !== w.ovf) report("overflow", w.ovf, o_overflow);
                end
            end
            if (start && !busy) predict_word();
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import mvg_pkg::*;

    localparam logic signed [19:0] CMAX = 20'sd524287;
    localparam logic signed [19:0] CMIN = 20'sh80000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_opcode;
    logic [1:0]         i_corner_slot;
    logic [9:0]         i_vertex_index;
    logic signed [19:0] i_coord_x, i_coord_y, i_coord_z;
    logic               o_done, o_result_kind, o_overflow;
    logic signed [63:0] o_volume_sum;
    logic signed [47:0] o_grad_x, o_grad_y, o_grad_z;
    int                 errors, pending;
    int                 words_sent;
    bit                 idle_on;

    mesh_volume_and_gradient u_dut (.*);

    mvg_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_opcode, .i_corner_slot,
        .i_vertex_index, .i_coord_x, .i_coord_y, .i_coord_z, .o_done,
        .o_result_kind, .o_volume_sum, .o_grad_x, .o_grad_y, .o_grad_z,
        .o_overflow, .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Drive one word at the falling edge and hold it until accepted
    task automatic send_word(input logic [1:0] op, input logic [1:0] slot,
                             input logic [9:0] idx, input logic signed [19:0] x,
                             input logic signed [19:0] y, input logic signed [19:0] z);
        if (idle_on && $urandom_range(99) < 14) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start = 1'b1;
        i_opcode = op;
        i_corner_slot = slot;
        i_vertex_index = idx;
        i_coord_x = x;
        i_coord_y = y;
        i_coord_z = z;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    function automatic logic signed [19:0] rand_coord();
        case ($urandom_range(7))
            0: rand_coord = CMAX;
            1: rand_coord = CMIN;
            2: rand_coord = 20'(int'($urandom_range(0, 64)) - 32);
            default: rand_coord = 20'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] rand_vertex();
        rand_vertex = ($urandom_range(1)) ? 10'($urandom_range(7)) : 10'($urandom);
    endfunction

    task automatic send_corner(input logic [1:0] slot);
        send_word(OP_CORNER, slot, rand_vertex(), rand_coord(), rand_coord(),
                  rand_coord());
    endtask

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        start = 1'b0;
        i_opcode = OP_CLEAR;
        i_corner_slot = SLOT_0;
        i_vertex_index = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        words_sent = 0;
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, missing corners, ignored codes, reads
        send_word(OP_READ, SLOT_0, 10'd0, '0, '0, '0);
        send_word(OP_CORNER, SLOT_LAST, 10'd3, CMAX, CMIN, CMAX);
        send_word(OP_CORNER, SLOT_0, 10'd0, CMAX, CMAX, CMAX);
        send_word(OP_CORNER, SLOT_1, 10'd1, CMIN, CMAX, CMAX);
        send_word(OP_CORNER, SLOT_LAST, 10'd1023, CMAX, CMIN, CMAX);
        send_word(OP_CORNER, SLOT_LAST, 10'd1023, CMIN, CMIN, CMIN);
        send_word(OP_CORNER, SLOT_NONE, 10'd5, CMAX, CMAX, CMAX);
        send_word(OP_NOP, SLOT_LAST, 10'd5, CMIN, CMIN, CMIN);
        send_word(OP_READ, SLOT_0, 10'd1023, '0, '0, '0);
        send_word(OP_READ, SLOT_0, 10'd0, '0, '0, '0);
        send_word(OP_READ, SLOT_0, 10'd1, '0, '0, '0);
        send_word(OP_CLEAR, SLOT_0, 10'd0, '0, '0, '0);
        send_word(OP_READ, SLOT_0, 10'd1023, '0, '0, '0);
        send_word(OP_CORNER, SLOT_1, 10'd2, 20'sd256, '0, '0);
        send_word(OP_CORNER, SLOT_LAST, 10'd4, '0, 20'sd256, 20'sd256);
        send_word(OP_READ, SLOT_0, 10'd2, '0, '0, '0);

        // Saturate volume and one gradient with a degenerate extreme triangle
        idle_on = 1'b0;
        for (int t = 0; t < 135; t++) begin
            send_word(OP_CORNER, SLOT_0, 10'd9, CMIN, CMIN, CMIN);
            send_word(OP_CORNER, SLOT_1, 10'd9, CMAX, CMIN, CMIN);
            send_word(OP_CORNER, SLOT_LAST, 10'd9, CMIN, CMAX, CMIN);
            if (t % 20 == 0) send_word(OP_READ, SLOT_0, 10'd9, '0, '0, '0);
        end
        send_word(OP_READ, SLOT_0, 10'd9, '0, '0, '0);
        send_word(OP_CLEAR, SLOT_0, 10'd0, '0, '0, '0);
        idle_on = 1'b1;

        // Random: mostly whole triangles, with reads, clears and noise
        while (words_sent < 600) begin
            idle_on = !(words_sent > 480 && words_sent < 540);
            case ($urandom_range(99)) inside
                [0:69]: begin
                    send_corner(SLOT_0);
                    send_corner(SLOT_1);
                    send_corner(SLOT_LAST);
                end
                [70:84]: send_word(OP_READ, SLOT_0, rand_vertex(), rand_coord(),
                                   rand_coord(), rand_coord());
                [85:86]: send_word(OP_CLEAR, 2'($urandom), 10'($urandom), rand_coord(),
                                   rand_coord(), rand_coord());
                [87:93]: send_corner(2'($urandom));
                default: send_word(OP_NOP, 2'($urandom), 10'($urandom), rand_coord(),
                                   rand_coord(), rand_coord());
            endcase
        end

        // Drain outstanding results, then let the last pass settle
        start = 1'b0;
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
design/mvg_pkg.sv
design/mesh_volume_and_gradient.sv
bench/mvg_checker.sv
bench/testbench.sv
